FILE: hw/rtl/multiplexed_digit_scan_assert.svh
// assertion macros used by the port-level checker file
`ifndef MULTIPLEXED_DIGIT_SCAN_ASSERT_SVH
`define MULTIPLEXED_DIGIT_SCAN_ASSERT_SVH

// same-cycle implication, off during reset
`define MDS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, off during reset
`define MDS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// next-cycle implication that also covers reset itself
`define MDS_ASSERT_NEXT_ALWAYS(label, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/mds_pkg.sv
// package: constants, types and helpers of the digit scan block
package mds_pkg;

  localparam int unsigned VALUE_W      = 16;
  localparam int unsigned MASK_W       = 40;
  localparam int unsigned SEG_W        = 8;
  localparam int unsigned DIGIT_W      = 4;
  localparam int unsigned DIGIT_MAX    = 9;
  localparam int unsigned PIN_OUT_W    = 12;
  localparam int unsigned CFG_IDX_W    = 3;
  localparam int unsigned CFG_DATA_W   = MASK_W;
  localparam int unsigned IN_DATA_W    = 8;
  localparam int unsigned OUT_DATA_W   = 16;
  localparam int unsigned RECIP_W      = VALUE_W + 2;
  localparam int unsigned PROD_W       = VALUE_W + RECIP_W;

  localparam int unsigned DIGIT_COUNT_DEF = 2;
  localparam int unsigned PIN_COUNT_DEF   = 12;

  // fixed pins touched by the dot overlays
  localparam int unsigned UPPER_DOT_PIN = 2;
  localparam int unsigned LOWER_DOT_PIN = 3;
  localparam int unsigned DOT_CLEAR_PIN = 4;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DISPLAY_ON   = 3'd0,
    CFG_SHOWN_VALUE  = 3'd1,
    CFG_UPPER_DOT_ON = 3'd2,
    CFG_LOWER_DOT_ON = 3'd3,
    CFG_MASKS_0_4    = 3'd4,
    CFG_MASKS_5_9    = 3'd5
  } mds_cfg_idx_t;

  typedef struct packed {
    logic                  display_on;
    logic                  upper_dot_on;
    logic                  lower_dot_on;
    logic [2*MASK_W-1:0]   masks;
  } mds_ctrl_t;

  function automatic longint unsigned pow10(input int unsigned n);
    longint unsigned acc;
    acc = 1;
    for (int unsigned k = 0; k < n; k++) begin
      acc = acc * 10;
    end
    return acc;
  endfunction

endpackage

FILE: hw/rtl/mds_cfg_regs.sv
// configuration registers and decimal split of the shown value
module mds_cfg_regs
  import mds_pkg::*;
#(
  parameter int unsigned DIGIT_COUNT = DIGIT_COUNT_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  cfg_we,
  input  logic [CFG_IDX_W-1:0]                  cfg_idx,
  input  logic [CFG_DATA_W-1:0]                 cfg_wdata,
  output mds_ctrl_t                             ctrl,
  output logic [DIGIT_COUNT-1:0][DIGIT_W-1:0]   digits,
  output logic [DIGIT_COUNT-1:0]                higher_nz
);

  logic                display_on_r;
  logic                upper_dot_r;
  logic                lower_dot_r;
  logic [MASK_W-1:0]   masks_lo_r;
  logic [MASK_W-1:0]   masks_hi_r;
  logic [DIGIT_COUNT:0][VALUE_W-1:0] quo_r;
  logic [DIGIT_COUNT:0][VALUE_W-1:0] quo_nxt;

  // value / 10^i by reciprocal multiply, exact over the whole 16-bit range
  for (genvar gi = 0; gi <= DIGIT_COUNT; gi++) begin : g_quo
    localparam longint unsigned DIV   = pow10(gi);
    localparam int unsigned     SH    = VALUE_W + $clog2(DIV);
    localparam longint unsigned RECIP = ((64'd1 << SH) + DIV - 1) / DIV;
    logic [PROD_W-1:0] prod;
    assign prod        = PROD_W'(cfg_wdata[VALUE_W-1:0]) * PROD_W'(RECIP);
    assign quo_nxt[gi] = VALUE_W'(prod >> SH);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      display_on_r <= 1'b0;
      upper_dot_r  <= 1'b0;
      lower_dot_r  <= 1'b0;
      masks_lo_r   <= '0;
      masks_hi_r   <= '0;
      quo_r        <= '0;
    end else if (cfg_we) begin
      case (mds_cfg_idx_t'(cfg_idx))
        CFG_DISPLAY_ON:   display_on_r <= cfg_wdata[0];
        CFG_SHOWN_VALUE:  quo_r        <= quo_nxt;
        CFG_UPPER_DOT_ON: upper_dot_r  <= cfg_wdata[0];
        CFG_LOWER_DOT_ON: lower_dot_r  <= cfg_wdata[0];
        CFG_MASKS_0_4:    masks_lo_r   <= cfg_wdata[MASK_W-1:0];
        CFG_MASKS_5_9:    masks_hi_r   <= cfg_wdata[MASK_W-1:0];
        default: ;
      endcase
    end
  end

  // per position: digit = q[i] - 10*q[i+1]
  for (genvar gp = 0; gp < DIGIT_COUNT; gp++) begin : g_digit
    logic [VALUE_W-1:0] diff;
    assign diff          = quo_r[gp] - (quo_r[gp+1] << 3) - (quo_r[gp+1] << 1);
    assign digits[gp]    = diff[DIGIT_W-1:0];
    assign higher_nz[gp] = (quo_r[gp+1] != '0);
  end

  assign ctrl.display_on   = display_on_r;
  assign ctrl.upper_dot_on = upper_dot_r;
  assign ctrl.lower_dot_on = lower_dot_r;
  assign ctrl.masks        = {masks_hi_r, masks_lo_r};

endmodule

FILE: hw/rtl/mds_scan_core.sv
// request register, pin pattern logic and result register
module mds_scan_core
  import mds_pkg::*;
#(
  parameter int unsigned DIGIT_COUNT = DIGIT_COUNT_DEF,
  parameter int unsigned PIN_COUNT   = PIN_COUNT_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic                                  in_tick,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [PIN_OUT_W-1:0]                  out_pins,
  output logic                                  out_pos,
  input  mds_ctrl_t                             ctrl,
  input  logic [DIGIT_COUNT-1:0][DIGIT_W-1:0]   digits,
  input  logic [DIGIT_COUNT-1:0]                higher_nz
);

  localparam int unsigned IDX_W = $clog2(DIGIT_COUNT);
  localparam logic [PIN_COUNT-1:0] BLANK = ~PIN_COUNT'((1 << DIGIT_COUNT) - 1);

  logic                 s1_valid_r;
  logic                 s1_tick_r;
  logic                 out_valid_r;
  logic [PIN_COUNT-1:0] pin_r;
  logic [PIN_COUNT-1:0] pin_nxt;
  logic [IDX_W-1:0]     idx_r;
  logic [IDX_W-1:0]     idx_nxt;
  logic                 out_free;
  logic                 advance;

  assign out_free = !out_valid_r || out_ready;
  assign advance  = s1_valid_r && out_free;
  assign in_ready = !s1_valid_r || out_free;

  always_comb begin
    logic [IDX_W-1:0]     nidx;
    logic [DIGIT_W-1:0]   dig;
    logic [SEG_W-1:0]     seg;
    logic [PIN_COUNT-1:0] pat;
    logic                 show;
    nidx    = (idx_r == IDX_W'(DIGIT_COUNT - 1)) ? '0 : idx_r + 1'b1;
    dig     = digits[nidx];
    show    = (dig != '0) || (nidx == '0) || higher_nz[nidx];
    seg     = (dig <= DIGIT_W'(DIGIT_MAX)) ? ctrl.masks[{dig, 3'b000} +: SEG_W] : '0;
    pat     = '0;
    pin_nxt = pin_r;
    idx_nxt = idx_r;
    if (s1_tick_r) begin
      if (!ctrl.display_on) begin
        pin_nxt = BLANK;
      end else begin
        idx_nxt = nidx;
        // mask bit b drives pin PIN_COUNT-1-b
        for (int j = 0; j < PIN_COUNT; j++) begin
          if (PIN_COUNT - 1 - j < SEG_W) begin
            pat[j] = seg[3'(PIN_COUNT - 1 - j)];
          end
        end
        for (int j = 0; j < DIGIT_COUNT; j++) begin
          if (nidx == IDX_W'(DIGIT_COUNT - 1 - j)) begin
            pat[j] = 1'b1;
          end
        end
        pin_nxt = show ? pat : BLANK;
        if (nidx == IDX_W'(1) && ctrl.upper_dot_on) begin
          pin_nxt[UPPER_DOT_PIN] = 1'b1;
          pin_nxt[DOT_CLEAR_PIN] = 1'b0;
        end
        if (nidx == '0 && ctrl.lower_dot_on) begin
          pin_nxt[LOWER_DOT_PIN] = 1'b1;
          pin_nxt[DOT_CLEAR_PIN] = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      pin_r       <= BLANK;
      idx_r       <= '0;
    end else begin
      if (in_valid && in_ready) begin
        s1_valid_r <= 1'b1;
      end else if (advance) begin
        s1_valid_r <= 1'b0;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
        pin_r       <= pin_nxt;
        idx_r       <= idx_nxt;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_tick_r <= in_tick;
    end
  end

  for (genvar gj = 0; gj < PIN_OUT_W; gj++) begin : g_pins
    if (gj < PIN_COUNT) begin : g_drv
      assign out_pins[gj] = pin_r[gj];
    end else begin : g_pad
      assign out_pins[gj] = 1'b0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_pos   = idx_r[0];

endmodule

FILE: hw/rtl/multiplexed_digit_scan.sv
// top level of the multiplexed decimal digit scanner
//
// drives a multiplexed numeric led display, one scan position per refresh tick
// channels:
//   in_*   : one request per refresh, in_tdata[0] = tick (0 only repeats the pins)
//   out_*  : one result per request: pin levels and the scan position now shown
//   cfg_*  : register writes, taken at any edge with cfg_we high, no read-back
// a request is taken when tvalid and tready are both high
// a taken request is held in the request register and moves on into the result
//   register once the output is free (request reg, result reg)
// throughput: one request per cycle while the output takes results; the pattern
//   logic between the two registers is a digit select, a byte mux and a few pin overrides
// writing shown_value splits it into decimal quotients in the same cycle
//   (one reciprocal multiply per quotient), so the next request sees it
// reset (rst_n low, synchronous): scan position 0, pins at the blanking
//   pattern, configuration registers zero, no result pending
// when out_tready is low the result holds, the request register still takes
//   one more request, and in_tready drops only once both are full
module multiplexed_digit_scan
  import mds_pkg::*;
#(
  parameter int unsigned DIGIT_COUNT = DIGIT_COUNT_DEF,
  parameter int unsigned PIN_COUNT   = PIN_COUNT_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // [0] tick, [7:1] zero
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // [11:0] pin_levels, [12] scan_position, [15:13] zero
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  mds_ctrl_t                           ctrl;
  logic [DIGIT_COUNT-1:0][DIGIT_W-1:0] digits;
  logic [DIGIT_COUNT-1:0]              higher_nz;
  logic [PIN_OUT_W-1:0]                pins;
  logic                                pos;

  // register file plus per-position digit split
  mds_cfg_regs #(
    .DIGIT_COUNT (DIGIT_COUNT)
  ) u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .ctrl      (ctrl),
    .digits    (digits),
    .higher_nz (higher_nz)
  );

  // scan state, pattern logic and the two pipeline registers
  mds_scan_core #(
    .DIGIT_COUNT (DIGIT_COUNT),
    .PIN_COUNT   (PIN_COUNT)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_tick   (in_tdata[0]),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_pins  (pins),
    .out_pos   (pos),
    .ctrl      (ctrl),
    .digits    (digits),
    .higher_nz (higher_nz)
  );

  // pack the result fields, lowest field first
  assign out_tdata = {(OUT_DATA_W - PIN_OUT_W - 1)'(0), pos, pins};

endmodule

FILE: hw/rtl/mds_checker.sv
// port-level checker for the digit scanner and its bind
`include "multiplexed_digit_scan_assert.svh"

module mds_checker
  import mds_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_tvalid,
  input logic                  in_tready,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [OUT_DATA_W-1:0] out_tdata
);

  // nothing left over from before reset
  `MDS_ASSERT_NEXT_ALWAYS(a_reset_clears, !rst_n, !out_tvalid, "result valid after reset")

  // a stalled result holds its value
  `MDS_ASSERT_NEXT(a_stall_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata), "stalled result changed")

  // with the output empty the request side never blocks
  `MDS_ASSERT_NOW(a_ready_when_empty, !out_tvalid, in_tready, "request blocked with empty output")

  // a fresh result comes from a request taken into the request register before it
  `MDS_ASSERT_NOW(a_result_has_request, $rose(out_tvalid), $past(in_tvalid && in_tready, 2), "result without request")

endmodule

bind multiplexed_digit_scan mds_checker u_mds_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

FILE: verif/testbench.sv
// self-checking testbench of the multiplexed digit scanner: predicted pin levels per refresh request
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import mds_pkg::*;

  // block configuration as built
  localparam int unsigned DIGITS = DIGIT_COUNT_DEF;
  localparam int unsigned PINS   = PIN_COUNT_DEF;

  // register indexes the block has no register behind, writes to them must be dropped
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_6 = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_7 = 3'd7;

  localparam int unsigned RANDOM_PHASES   = 22;
  localparam int unsigned ITEMS_PER_PHASE = 50;
  localparam int unsigned SETTLE_CYCLES   = 4;   // margin after the last result
  localparam int unsigned DRAIN_CYCLES    = 8;
  localparam int unsigned WATCHDOG_LIMIT  = 5000;
  localparam int unsigned REPORT_LIMIT    = 10;

  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

  // one result as it sits in out_tdata[12:0]
  typedef struct packed {
    logic                 scan;
    logic [PIN_OUT_W-1:0] pins;
  } scan_result_t;

  // own copy of registers and scan state, predicts the pins for every request
  class scan_scoreboard;
    logic               display_on;
    logic               upper_dot_on;
    logic               lower_dot_on;
    logic [VALUE_W-1:0] shown_value;
    logic [MASK_W-1:0]  masks_lo;
    logic [MASK_W-1:0]  masks_hi;
    int unsigned        scan_idx;
    logic [31:0]        pin_reg;
    scan_result_t       expected_pins[$];
    int unsigned        mismatches;

    function new();
      display_on   = 1'b0;
      upper_dot_on = 1'b0;
      lower_dot_on = 1'b0;
      shown_value  = '0;
      masks_lo     = '0;
      masks_hi     = '0;
      scan_idx     = 0;
      pin_reg      = blank_pins();
      mismatches   = 0;
    endfunction

    // digit pins low, segment pins high
    function logic [31:0] blank_pins();
      logic [31:0] all_pins;
      logic [31:0] digit_pins;
      all_pins   = (32'd1 << PINS) - 32'd1;
      digit_pins = (32'd1 << DIGITS) - 32'd1;
      return all_pins & ~digit_pins;
    endfunction

    // mask bit b lands on pin PINS-1-b, every other pin low
    function logic [31:0] segment_pins(int unsigned d);
      logic [SEG_W-1:0] m;
      logic [31:0]      p;
      m = (d < 5) ? masks_lo[8*d +: 8] : masks_hi[8*(d-5) +: 8];
      p = '0;
      for (int b = 0; b < SEG_W && b < PINS; b++) begin
        if (m[b]) p[PINS-1-b] = 1'b1;
      end
      return p;
    endfunction

    function void drive_pin(int unsigned pin, logic level);
      if (pin < PINS) pin_reg[pin] = level;
    endfunction

    function void apply_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_DISPLAY_ON:   display_on   = data[0];
        CFG_SHOWN_VALUE:  shown_value  = data[VALUE_W-1:0];
        CFG_UPPER_DOT_ON: upper_dot_on = data[0];
        CFG_LOWER_DOT_ON: lower_dot_on = data[0];
        CFG_MASKS_0_4:    masks_lo     = data[MASK_W-1:0];
        CFG_MASKS_5_9:    masks_hi     = data[MASK_W-1:0];
        default: ;
      endcase
    endfunction

    function void note_request(logic tick);
      int unsigned  num;
      int unsigned  digit;
      scan_result_t r;
      if (tick) begin
        if (!display_on) begin
          // blanked, scan position frozen
          pin_reg = blank_pins();
        end else begin
          scan_idx = (scan_idx + 1) % DIGITS;
          num = 32'(shown_value);
          for (int i = 0; i < scan_idx; i++) num = num / 10;
          digit = num % 10;
          // leading zeros blank, unless units or something nonzero further up
          if (digit != 0 || scan_idx == 0 || num >= 10) begin
            pin_reg = segment_pins(digit);
            drive_pin(DIGITS - 1 - scan_idx, 1'b1);
          end else begin
            pin_reg = blank_pins();
          end
          if (scan_idx == 1 && upper_dot_on) begin
            drive_pin(UPPER_DOT_PIN, 1'b1);
            drive_pin(DOT_CLEAR_PIN, 1'b0);
          end
          if (scan_idx == 0 && lower_dot_on) begin
            drive_pin(LOWER_DOT_PIN, 1'b1);
            drive_pin(DOT_CLEAR_PIN, 1'b0);
          end
        end
      end
      r.pins = pin_reg[PIN_OUT_W-1:0];
      r.scan = scan_idx[0];
      expected_pins.push_back(r);
    endfunction

    function void check_result(logic [OUT_DATA_W-1:0] data);
      scan_result_t got;
      scan_result_t want;
      got = data[PIN_OUT_W:0];
      if (expected_pins.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("unexpected result: pins %h scan %0d", got.pins, got.scan);
        return;
      end
      want = expected_pins.pop_front();
      if (got.pins !== want.pins || got.scan !== want.scan) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("mismatch: pin_levels exp %h got %h, scan_position exp %0d got %0d",
                   want.pins, got.pins, want.scan, got.scan);
      end
    endfunction

    function int unsigned pending();
      return expected_pins.size();
    endfunction
  endclass

  // clock, 2 ns period
  logic clk = 1'b0;
  always #1 clk = ~clk;

  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;
  logic                  out_tvalid;
  logic                  out_tready = 1'b1;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  multiplexed_digit_scan u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),    // [0] tick, [7:1] zero
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),   // [11:0] pin_levels, [12] scan_position, [15:13] zero
    .cfg_we     (cfg_we),
    .cfg_idx    (cfg_idx),
    .cfg_wdata  (cfg_wdata)
  );

  scan_scoreboard sb;
  idle_mode_t     idle_mode = IDLE_NONE;
  int unsigned    idle_cycles = 0;

  function automatic bit chance(int unsigned pct);
    return $urandom_range(0, 99) < pct;
  endfunction

  // sender holds back in its idle phases
  function automatic bit sender_idles();
    return (idle_mode == IDLE_SENDER && chance(77)) || (idle_mode == IDLE_BOTH && chance(13));
  endfunction

  function automatic bit receiver_stalls();
    return (idle_mode == IDLE_RECEIVER && chance(77)) || (idle_mode == IDLE_BOTH && chance(13));
  endfunction

  // receiver side: out_tready redrawn every cycle according to the phase
  always @(posedge clk) begin
    out_tready <= !receiver_stalls();
  end

  // monitor: values seen here are the ones present at the edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) sb.note_request(in_tdata[0]);
      if (out_tvalid && out_tready) sb.check_result(out_tdata);
      // watchdog on cycles with no handshake on either channel
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("multiplexed_digit_scan verification failed");
        $finish;
      end
    end
  end

  // one request; in_tvalid stays high into the next request when there is no gap
  task automatic send_request(input logic tick);
    while (sender_idles()) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {{(IN_DATA_W-1){1'b0}}, tick};
    do @(posedge clk); while (!in_tready);
  endtask

  // stop sending and wait until every predicted result has come out
  task automatic settle();
    in_tvalid <= 1'b0;
    // let the monitor log the last request before counting
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // caller lowers cfg_we after its last write
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    sb.apply_write(idx, data);
  endtask

  task automatic apply_setting(input logic on, input logic [VALUE_W-1:0] value,
                               input logic upper, input logic lower,
                               input logic [MASK_W-1:0] m04, input logic [MASK_W-1:0] m59);
    write_reg(CFG_SHOWN_VALUE, CFG_DATA_W'(value));
    write_reg(CFG_UPPER_DOT_ON, CFG_DATA_W'(upper));
    write_reg(CFG_LOWER_DOT_ON, CFG_DATA_W'(lower));
    write_reg(CFG_MASKS_0_4, m04);
    write_reg(CFG_MASKS_5_9, m59);
    write_reg(CFG_DISPLAY_ON, CFG_DATA_W'(on));
    cfg_we <= 1'b0;
  endtask

  function automatic logic [MASK_W-1:0] random_masks();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      default: return MASK_W'({$urandom, $urandom});
    endcase
  endfunction

  // random setting, weighted toward leading zeros, zero units and the extremes
  task automatic apply_random_setting();
    logic [VALUE_W-1:0] value;
    logic [MASK_W-1:0]  m04;
    logic [MASK_W-1:0]  m59;
    case ($urandom_range(0, 7))
      0:       value = '0;
      1:       value = '1;
      2:       value = VALUE_W'($urandom_range(0, 9));
      3:       value = VALUE_W'($urandom_range(10, 99));
      4:       value = VALUE_W'($urandom_range(1, 655) * 100);
      5:       value = VALUE_W'($urandom_range(1, 9) * 10);
      default: value = VALUE_W'($urandom);
    endcase
    m04 = random_masks();
    m59 = random_masks();
    // now and then a write to an index with no register
    if (chance(15))
      write_reg(chance(50) ? CFG_SPARE_6 : CFG_SPARE_7, CFG_DATA_W'({$urandom, $urandom}));
    apply_setting(!chance(12), value, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                  m04, m59);
  endtask

  initial begin
    sb = new();
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    cfg_we    <= 1'b0;
    cfg_idx   <= CFG_DISPLAY_ON;
    cfg_wdata <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset state: display off, ticks give the blanking pattern
    send_request(1'b1);
    send_request(1'b0);
    send_request(1'b1);

    // largest value, both dots, every segment on, both scan positions
    settle();
    apply_setting(1'b1, '1, 1'b1, 1'b1, '1, '1);
    send_request(1'b1);
    send_request(1'b1);
    send_request(1'b1);
    send_request(1'b0);

    // zero digit shown because a higher digit is nonzero, distinct masks
    settle();
    apply_setting(1'b1, 16'd1000, 1'b0, 1'b1, 40'h4B2D96C37E, 40'hF00FA518E1);
    send_request(1'b1);
    send_request(1'b1);

    // leading zero blanked, upper dot still lands on the blank pattern
    settle();
    apply_setting(1'b1, 16'd5, 1'b1, 1'b0, 40'h4B2D96C37E, 40'hF00FA518E1);
    send_request(1'b1);
    send_request(1'b1);
    send_request(1'b1);

    // value zero: units zero always shown
    settle();
    apply_setting(1'b1, 16'd0, 1'b0, 1'b0, 40'h4B2D96C37E, 40'hF00FA518E1);
    send_request(1'b1);
    send_request(1'b1);

    // zero units under a nonzero tens digit
    settle();
    apply_setting(1'b1, 16'd10, 1'b0, 1'b0, 40'h4B2D96C37E, 40'hF00FA518E1);
    send_request(1'b1);
    send_request(1'b1);

    // writes to spare indexes dropped, then disabled ticks freeze the scan
    settle();
    write_reg(CFG_SPARE_6, '1);
    write_reg(CFG_SPARE_7, '1);
    write_reg(CFG_DISPLAY_ON, '0);
    cfg_we <= 1'b0;
    send_request(1'b1);
    send_request(1'b0);
    send_request(1'b1);

    // random phases, cycling through the idle modes
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      settle();
      apply_random_setting();
      idle_mode = idle_mode_t'(ph % 4);
      for (int k = 0; k < ITEMS_PER_PHASE; k++) send_request(!chance(20));
    end

    settle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("multiplexed_digit_scan verification clean");
    end else begin
      $display("multiplexed_digit_scan verification failed");
    end
    $finish;
  end

endmodule
